// ===== hw/rtl/wpt_pkg.sv =====
// Shared types, constants and tables for the waypoint path tracker.
// No dependencies; every other file refers to it by scoped names.
package wpt_pkg;

  // Path store geometry
  localparam int PATH_DEPTH = 64;
  localparam int AW         = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW         = $clog2(PATH_DEPTH + 1);
  localparam int TW         = ((AW > 6) ? AW : 6) + 1;
  localparam int CNT_W      = (CW > 6) ? CW : 6;

  // Scan pipeline depth after the read address, square root steps
  localparam int SCAN_LAT   = 3;
  localparam int ROOT_STEPS = 32;

  // Angle unit widths (angles in Q16 radians)
  localparam int AT_W         = 51;
  localparam int Z_W          = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic signed [Z_W-1:0] PI_Q16      = 20'sd205887;
  localparam logic signed [Z_W-1:0] TWO_PI_Q16  = 20'sd411774;
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD = 3'd0,
    CFG_LIN_GAIN  = 3'd1,
    CFG_ANG_GAIN  = 3'd2,
    CFG_XT_GAIN   = 3'd3,
    CFG_GOAL      = 3'd4,
    CFG_DEADBAND  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POSE   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POSE_MUL,
    ST_POSE_ATAN,
    ST_POSE_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_TGT,
    ST_TGT_RD,
    ST_DELTA,
    ST_SQ,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_HEAD_WAIT,
    ST_ERR,
    ST_CTG,
    ST_CORR,
    ST_CORR_WAIT,
    ST_SUM,
    ST_ANG,
    ST_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    AT_IDLE,
    AT_NORM,
    AT_ROT
  } atan_state_t;

  // Controller to datapath
  typedef struct packed {
    logic          wp_clear;
    logic          wp_append;
    logic          pose_cap;
    logic          pose_mul;
    logic          pose_atan;
    logic          yaw_load;
    logic          scan_init;
    logic          scan_issue;
    logic [AW-1:0] rd_addr;
    logic          tgt_load;
    logic          tgt_rd;
    logic          delta_load;
    logic          sq_load;
    logic          root_init;
    logic          root_step;
    logic          d_load;
    logic          err_load;
    logic          ctg_load;
    logic          corr_start;
    logic          sum_load;
    logic          ang_load;
    logic          out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CW-1:0] total;
    logic          atan_busy;
    logic          need_corr;
  } dp_status_t;

endpackage

// ===== hw/rtl/waypoint_path_tracker_top.sv =====
// Top level of the waypoint path tracker: controller plus datapath.
// Depends on wpt_pkg, wpt_ctrl, wpt_dp (and wpt_atan below it).
//
// Usage:
//  Input channel (in_valid / in_stall) carries one word: an operation code
//  with position and quaternion fields. A pose word runs through the
//  quaternion products, the operand normalization and the 16 rotation steps
//  of the shared atan unit. A control tick on a path of N waypoints passes
//  one waypoint per cycle through the nearest-point scan pipeline, then takes
//  32 square-root steps (the heading atan runs alongside), then a second
//  atan pass for the cross-track correction when outside the deadband.
//  The block takes one word at a time; in_stall is high while it works.
//  A tick produces one result word on out_valid / out_stall; a tick on an
//  empty path and all other operations produce none. The result sits in an
//  output register, so the next input word is taken while it waits; a tick
//  that finishes while the receiver still stalls holds until the slot frees.
//  Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
//  must write it only while idle, as the block itself does not enforce this.
//  Synchronous reset (rst_n low) empties the path, zeroes the pose, restores
//  the register defaults and drops out_valid.
module waypoint_path_tracker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic signed [31:0]               in_pos_x,
  input  logic signed [31:0]               in_pos_y,
  input  logic signed [15:0]               in_quat_x,
  input  logic signed [15:0]               in_quat_y,
  input  logic signed [15:0]               in_quat_z,
  input  logic signed [15:0]               in_quat_w,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [31:0]               out_linear_velocity,
  output logic signed [31:0]               out_angular_velocity,
  output logic                             out_arrived,
  output logic [5:0]                       out_target_index,
  input  logic                             cfg_we,
  input  logic [wpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wpt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  wpt_pkg::ctrl_cmd_t  cmd;
  wpt_pkg::dp_status_t status;

  wpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status)
  );

  wpt_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_quat_x            (in_quat_x),
    .in_quat_y            (in_quat_y),
    .in_quat_z            (in_quat_z),
    .in_quat_w            (in_quat_w),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_linear_velocity  (out_linear_velocity),
    .out_angular_velocity (out_angular_velocity),
    .out_arrived          (out_arrived),
    .out_target_index     (out_target_index)
  );

  // A new result never overwrites a word the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending output word");

  // The shared atan unit is only started when free
  a_atan_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pose_atan || cmd.root_init || cmd.corr_start) |-> !status.atan_busy)
    else $error("atan unit started while busy");

  // An accepted clear empties the path on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_operation == wpt_pkg::OP_CLEAR))
      |=> (status.total == '0))
    else $error("path not empty after clear");

endmodule

// ===== hw/rtl/wpt_atan.sv =====
// Iterative atan2 unit: normalizes operands one shift per cycle, then runs
// a 16-step vectoring CORDIC; a zero y operand skips both. Depends on wpt_pkg.
module wpt_atan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [wpt_pkg::AT_W-1:0]    y_in,
  input  logic signed [wpt_pkg::AT_W-1:0]    x_in,
  output logic                               busy,
  output logic signed [wpt_pkg::Z_W-1:0]     z_out
);

  localparam int CX_W = 34;

  wpt_pkg::atan_state_t state_r, state_nxt;

  logic [wpt_pkg::AT_W-1:0]          nx_r, ny_r;
  logic signed [CX_W-1:0]            cx_r, cy_r;
  logic signed [wpt_pkg::Z_W-1:0]    z_r, z_out_r;
  logic [wpt_pkg::STEP_W-1:0]        step_r;
  logic                              xneg_r, yneg_r;

  logic [wpt_pkg::AT_W-1:0]          ax, ay;
  logic                              big, low;
  logic signed [CX_W-1:0]            cx_sh, cy_sh, cx_nxt, cy_nxt;
  logic signed [wpt_pkg::Z_W-1:0]    z_nxt;
  logic                              last_step;

  // Clamp to the first quadrant, then fold into the operand quadrant
  function automatic logic signed [wpt_pkg::Z_W-1:0] fold(
    input logic signed [wpt_pkg::Z_W-1:0] z,
    input logic xneg,
    input logic yneg
  );
    logic signed [wpt_pkg::Z_W-1:0] zc;
    zc = z;
    if (zc < 0) zc = '0;
    if (zc > wpt_pkg::HALF_PI_Q16) zc = wpt_pkg::HALF_PI_Q16;
    if (xneg) zc = wpt_pkg::PI_Q16 - zc;
    if (yneg) zc = -zc;
    return zc;
  endfunction

  assign ax = x_in[wpt_pkg::AT_W-1] ? wpt_pkg::AT_W'(-x_in) : wpt_pkg::AT_W'(x_in);
  assign ay = y_in[wpt_pkg::AT_W-1] ? wpt_pkg::AT_W'(-y_in) : wpt_pkg::AT_W'(y_in);

  // Normalization window [2^29, 2^30)
  assign big = (|nx_r[wpt_pkg::AT_W-1:30]) || (|ny_r[wpt_pkg::AT_W-1:30]);
  assign low = !(|nx_r[wpt_pkg::AT_W-1:29]) && !(|ny_r[wpt_pkg::AT_W-1:29]);

  // One CORDIC micro-rotation
  always_comb begin
    cx_sh = cx_r >>> step_r;
    cy_sh = cy_r >>> step_r;
    if (!cy_r[CX_W-1]) begin
      cx_nxt = cx_r + cy_sh;
      cy_nxt = cy_r - cx_sh;
      z_nxt  = z_r + wpt_pkg::ATAN_TAB[step_r];
    end else begin
      cx_nxt = cx_r - cy_sh;
      cy_nxt = cy_r + cx_sh;
      z_nxt  = z_r - wpt_pkg::ATAN_TAB[step_r];
    end
  end

  assign last_step = (step_r == wpt_pkg::STEP_W'(wpt_pkg::CORDIC_STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpt_pkg::AT_IDLE: begin
        if (start && (ay != '0)) state_nxt = wpt_pkg::AT_NORM;
      end
      wpt_pkg::AT_NORM: begin
        if (!big && !low) state_nxt = wpt_pkg::AT_ROT;
      end
      wpt_pkg::AT_ROT: begin
        if (last_step) state_nxt = wpt_pkg::AT_IDLE;
      end
      default: state_nxt = wpt_pkg::AT_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state_r != wpt_pkg::AT_IDLE);
  end

  assign z_out = z_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpt_pkg::AT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand and angle registers
  always_ff @(posedge clk) begin
    case (state_r)
      wpt_pkg::AT_IDLE: begin
        if (start) begin
          xneg_r <= x_in[wpt_pkg::AT_W-1];
          yneg_r <= y_in[wpt_pkg::AT_W-1];
          nx_r   <= ax;
          ny_r   <= ay;
          // zero y: no rotation, result is 0 or pi
          if (ay == '0) z_out_r <= fold('0, x_in[wpt_pkg::AT_W-1], 1'b0);
        end
      end
      wpt_pkg::AT_NORM: begin
        if (big) begin
          nx_r <= nx_r >> 1;
          ny_r <= ny_r >> 1;
        end else if (low) begin
          nx_r <= nx_r << 1;
          ny_r <= ny_r << 1;
        end else begin
          cx_r   <= CX_W'(nx_r);
          cy_r   <= CX_W'(ny_r);
          z_r    <= '0;
          step_r <= '0;
        end
      end
      wpt_pkg::AT_ROT: begin
        cx_r   <= cx_nxt;
        cy_r   <= cy_nxt;
        z_r    <= z_nxt;
        step_r <= step_r + 1'b1;
        if (last_step) z_out_r <= fold(z_nxt, xneg_r, yneg_r);
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/wpt_dp.sv =====
// Datapath: configuration registers, waypoint memory, pose, nearest-point
// scan pipeline, square root, atan unit and output word. Depends on wpt_pkg.
module wpt_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wpt_pkg::ctrl_cmd_t                  cmd,
  output wpt_pkg::dp_status_t                 status,
  input  logic signed [31:0]                  in_pos_x,
  input  logic signed [31:0]                  in_pos_y,
  input  logic signed [15:0]                  in_quat_x,
  input  logic signed [15:0]                  in_quat_y,
  input  logic signed [15:0]                  in_quat_z,
  input  logic signed [15:0]                  in_quat_w,
  input  logic                                cfg_we,
  input  logic [wpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wpt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic signed [31:0]                  out_linear_velocity,
  output logic signed [31:0]                  out_angular_velocity,
  output logic                                out_arrived,
  output logic [5:0]                          out_target_index
);

  // Configuration
  logic [5:0]  look_r;
  logic [15:0] lgain_r, again_r, xgain_r;
  logic [30:0] goal_r;
  logic [14:0] dband_r;

  // Path and pose state
  logic [wpt_pkg::CW-1:0] total_r;
  logic signed [31:0]     robot_x_r, robot_y_r;
  logic signed [15:0]     yaw_r;
  logic [63:0]            wp_mem [wpt_pkg::PATH_DEPTH];
  logic [63:0]            rd_r;
  logic [wpt_pkg::AW-1:0] raddr;

  // Pose pipeline
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0] p_wz_r, p_xy_r, p_yy_r, p_zz_r;

  // Scan pipeline
  logic                   va_r, vb_r, vc_r;
  logic [wpt_pkg::AW-1:0] ia_r, ib_r, ic_r, best_r;
  logic [31:0]            mx_r, my_r;
  logic [63:0]            sqx_r, sqy_r;
  logic [64:0]            best_d_r, scan_d;
  logic                   best_vld_r;
  logic signed [32:0]     sdx, sdy;

  // Target geometry
  logic [wpt_pkg::AW-1:0] tgt_r, tgt_nxt;
  logic [wpt_pkg::TW-1:0] tgt_sum, tgt_last;
  logic signed [32:0]     dx_r, dy_r;
  logic [31:0]            hax, hay;
  logic                   hshift;
  logic [63:0]            hsx_r, hsy_r;
  logic                   hs_r;
  logic [63:0]            rn_r, rres_r, rbit_r, rtry;
  logic [32:0]            d_r;

  // Steering
  logic signed [20:0]              err_r, err_raw, err_wrap;
  logic [20:0]                     err_mag;
  logic [48:0]                     lraw_r, xtd_r;
  logic                            need_corr_r;
  logic signed [21:0]              sum_r, corr;
  logic signed [38:0]              angp_r, angsh;
  logic [40:0]                     linsh;
  logic [31:0]                     lin_sat, ang_sat;
  logic                            arrived;

  // Angle unit
  logic                              at_start, at_busy;
  logic signed [wpt_pkg::AT_W-1:0]   at_y, at_x, pose_num, pose_den;
  logic signed [wpt_pkg::Z_W-1:0]    at_z;

  // Output word
  logic signed [31:0] out_lin_r, out_ang_r;
  logic               out_arr_r;
  logic [5:0]         out_tgt_r;

  function automatic logic signed [wpt_pkg::AT_W-1:0] sx32(input logic signed [31:0] v);
    return {{(wpt_pkg::AT_W-32){v[31]}}, v};
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    return v[32] ? 32'(-v) : 32'(v);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r  <= 6'd3;
      lgain_r <= 16'd128;
      again_r <= 16'd205;
      xgain_r <= 16'd205;
      goal_r  <= 31'd19661;
      dband_r <= 15'd819;
    end else if (cfg_we) begin
      case (wpt_pkg::cfg_idx_t'(cfg_index))
        wpt_pkg::CFG_LOOKAHEAD: look_r  <= cfg_wdata[5:0];
        wpt_pkg::CFG_LIN_GAIN:  lgain_r <= cfg_wdata[15:0];
        wpt_pkg::CFG_ANG_GAIN:  again_r <= cfg_wdata[15:0];
        wpt_pkg::CFG_XT_GAIN:   xgain_r <= cfg_wdata[15:0];
        wpt_pkg::CFG_GOAL:      goal_r  <= cfg_wdata[30:0];
        wpt_pkg::CFG_DEADBAND:  dband_r <= cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // Path count and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      robot_x_r <= '0;
      robot_y_r <= '0;
      yaw_r     <= '0;
    end else begin
      if (cmd.wp_clear) begin
        total_r <= '0;
      end else if (cmd.wp_append && (total_r < wpt_pkg::CW'(wpt_pkg::PATH_DEPTH))) begin
        total_r <= total_r + 1'b1;
      end
      if (cmd.pose_cap) begin
        robot_x_r <= in_pos_x;
        robot_y_r <= in_pos_y;
      end
      if (cmd.yaw_load) yaw_r <= 16'((at_z + 20'sd4) >>> 3);
    end
  end

  // Waypoint memory: x in the upper half, y in the lower
  assign raddr = cmd.scan_issue ? cmd.rd_addr : tgt_r;

  always_ff @(posedge clk) begin
    if (cmd.wp_append && (total_r < wpt_pkg::CW'(wpt_pkg::PATH_DEPTH))) begin
      wp_mem[total_r[wpt_pkg::AW-1:0]] <= {in_pos_x, in_pos_y};
    end
    rd_r <= wp_mem[raddr];
  end

  // Quaternion products
  always_ff @(posedge clk) begin
    if (cmd.pose_cap) begin
      qx_r <= in_quat_x;
      qy_r <= in_quat_y;
      qz_r <= in_quat_z;
      qw_r <= in_quat_w;
    end
    if (cmd.pose_mul) begin
      p_wz_r <= qw_r * qz_r;
      p_xy_r <= qx_r * qy_r;
      p_yy_r <= qy_r * qy_r;
      p_zz_r <= qz_r * qz_r;
    end
  end

  assign pose_num = (sx32(p_wz_r) + sx32(p_xy_r)) <<< 1;
  assign pose_den = (wpt_pkg::AT_W'(1) <<< 28) - ((sx32(p_yy_r) + sx32(p_zz_r)) <<< 1);

  // Scan pipeline: read, magnitude, square, compare
  assign sdx    = $signed({rd_r[63], rd_r[63:32]}) - $signed({robot_x_r[31], robot_x_r});
  assign sdy    = $signed({rd_r[31], rd_r[31:0]}) - $signed({robot_y_r[31], robot_y_r});
  assign scan_d = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      va_r <= cmd.scan_issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      if (cmd.scan_init) begin
        best_vld_r <= 1'b0;
      end else if (vc_r && (!best_vld_r || (scan_d < best_d_r))) begin
        best_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ia_r  <= raddr;
    ib_r  <= ia_r;
    ic_r  <= ib_r;
    mx_r  <= mag33(sdx);
    my_r  <= mag33(sdy);
    sqx_r <= mx_r * mx_r;
    sqy_r <= my_r * my_r;
    if (vc_r && (!best_vld_r || (scan_d < best_d_r))) begin
      best_d_r <= scan_d;
      best_r   <= ic_r;
    end
  end

  // Target: nearest plus lookahead, clamped to the last waypoint
  assign tgt_sum  = wpt_pkg::TW'(best_r) + wpt_pkg::TW'(look_r);
  assign tgt_last = wpt_pkg::TW'(total_r) - wpt_pkg::TW'(1);
  assign tgt_nxt  = (tgt_sum > tgt_last) ? wpt_pkg::AW'(tgt_last) : wpt_pkg::AW'(tgt_sum);

  // Distance: pre-shift when a magnitude reaches 2^31, then square
  assign hax    = mag33(dx_r);
  assign hay    = mag33(dy_r);
  assign hshift = hax[31] | hay[31];
  assign rtry   = rres_r + rbit_r;

  always_ff @(posedge clk) begin
    if (cmd.tgt_load) tgt_r <= tgt_nxt;
    if (cmd.delta_load) begin
      dx_r <= sdx;
      dy_r <= sdy;
    end
    if (cmd.sq_load) begin
      hsx_r <= hshift ? (hax >> 1) * (hax >> 1) : hax * hax;
      hsy_r <= hshift ? (hay >> 1) * (hay >> 1) : hay * hay;
      hs_r  <= hshift;
    end
    // Restoring square root, one result bit per step
    if (cmd.root_init) begin
      rn_r   <= hsx_r + hsy_r;
      rres_r <= '0;
      rbit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.root_step) begin
      if (rn_r >= rtry) begin
        rn_r   <= rn_r - rtry;
        rres_r <= (rres_r >> 1) + rbit_r;
      end else begin
        rres_r <= rres_r >> 1;
      end
      rbit_r <= rbit_r >> 2;
    end
    if (cmd.d_load) d_r <= hs_r ? {rres_r[31:0], 1'b0} : {1'b0, rres_r[31:0]};
  end

  // Heading error wrapped to [-pi, pi)
  assign err_raw = 21'(at_z) - (21'(yaw_r) <<< 3);
  always_comb begin
    err_wrap = err_raw;
    if (err_raw >= 21'(wpt_pkg::PI_Q16)) begin
      err_wrap = err_raw - 21'(wpt_pkg::TWO_PI_Q16);
    end else if (err_raw < -21'(wpt_pkg::PI_Q16)) begin
      err_wrap = err_raw + 21'(wpt_pkg::TWO_PI_Q16);
    end
  end
  assign err_mag = err_r[20] ? 21'(-err_r) : 21'(err_r);

  assign corr = need_corr_r ? 22'(at_z) : '0;

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      err_r  <= err_wrap;
      lraw_r <= lgain_r * d_r;
    end
    if (cmd.ctg_load) begin
      xtd_r       <= xgain_r * d_r;
      need_corr_r <= err_mag > {6'd0, dband_r, 3'd0};
    end
    if (cmd.sum_load) sum_r <= (err_r >= 0) ? 22'(err_r) + corr : 22'(err_r) - corr;
    if (cmd.ang_load) angp_r <= $signed({1'b0, again_r}) * sum_r;
  end

  // Angle operand select
  assign at_start = cmd.pose_atan | cmd.root_init | cmd.corr_start;
  always_comb begin
    if (cmd.pose_atan) begin
      at_y = pose_num;
      at_x = pose_den;
    end else if (cmd.root_init) begin
      at_y = wpt_pkg::AT_W'(dy_r);
      at_x = wpt_pkg::AT_W'(dx_r);
    end else begin
      at_y = {2'b00, xtd_r};
      at_x = {1'b0, 50'(lraw_r) + 50'd256};
    end
  end

  wpt_atan u_atan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (at_start),
    .y_in  (at_y),
    .x_in  (at_x),
    .busy  (at_busy),
    .z_out (at_z)
  );

  // Saturation and goal check
  assign linsh   = lraw_r[48:8];
  assign lin_sat = (|linsh[40:31]) ? 32'h7FFF_FFFF : linsh[31:0];
  assign angsh   = angp_r >>> 8;
  always_comb begin
    if ((&angsh[38:31]) || !(|angsh[38:31])) begin
      ang_sat = angsh[31:0];
    end else begin
      ang_sat = angsh[38] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end
  assign arrived = d_r < {2'b00, goal_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lin_r <= arrived ? '0 : lin_sat;
      out_ang_r <= arrived ? '0 : ang_sat;
      out_arr_r <= arrived;
      out_tgt_r <= 6'(tgt_r);
    end
  end

  assign out_linear_velocity  = out_lin_r;
  assign out_angular_velocity = out_ang_r;
  assign out_arrived          = out_arr_r;
  assign out_target_index     = out_tgt_r;

  assign status.total     = total_r;
  assign status.atan_busy = at_busy;
  assign status.need_corr = need_corr_r;

endmodule

// ===== hw/rtl/wpt_ctrl.sv =====
// Controller: sequences each accepted word through the datapath and owns
// the input stall and the output valid. Depends on wpt_pkg.
module wpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_operation,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wpt_pkg::ctrl_cmd_t   cmd,
  input  wpt_pkg::dp_status_t  status
);

  wpt_pkg::ctrl_state_t      state_r, state_nxt;
  logic [wpt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r;
  logic                      out_free;
  logic                      scan_last;

  assign out_free  = !out_valid_r || !out_stall;
  assign scan_last = (cnt_r == wpt_pkg::CNT_W'(status.total) - wpt_pkg::CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (wpt_pkg::op_t'(in_operation))
            wpt_pkg::OP_POSE: state_nxt = wpt_pkg::ST_POSE_MUL;
            wpt_pkg::OP_TICK: begin
              if (status.total != '0) state_nxt = wpt_pkg::ST_SCAN;
            end
            default: state_nxt = wpt_pkg::ST_IDLE;
          endcase
        end
      end
      wpt_pkg::ST_POSE_MUL:  state_nxt = wpt_pkg::ST_POSE_ATAN;
      wpt_pkg::ST_POSE_ATAN: state_nxt = wpt_pkg::ST_POSE_WAIT;
      wpt_pkg::ST_POSE_WAIT: begin
        if (!status.atan_busy) state_nxt = wpt_pkg::ST_IDLE;
      end
      wpt_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = wpt_pkg::ST_DRAIN;
      end
      wpt_pkg::ST_DRAIN: begin
        if (cnt_r == wpt_pkg::CNT_W'(wpt_pkg::SCAN_LAT - 1)) state_nxt = wpt_pkg::ST_TGT;
      end
      wpt_pkg::ST_TGT:       state_nxt = wpt_pkg::ST_TGT_RD;
      wpt_pkg::ST_TGT_RD:    state_nxt = wpt_pkg::ST_DELTA;
      wpt_pkg::ST_DELTA:     state_nxt = wpt_pkg::ST_SQ;
      wpt_pkg::ST_SQ:        state_nxt = wpt_pkg::ST_ROOT_INIT;
      wpt_pkg::ST_ROOT_INIT: state_nxt = wpt_pkg::ST_ROOT;
      wpt_pkg::ST_ROOT: begin
        if (cnt_r == wpt_pkg::CNT_W'(wpt_pkg::ROOT_STEPS - 1)) state_nxt = wpt_pkg::ST_HEAD_WAIT;
      end
      wpt_pkg::ST_HEAD_WAIT: begin
        if (!status.atan_busy) state_nxt = wpt_pkg::ST_ERR;
      end
      wpt_pkg::ST_ERR: state_nxt = wpt_pkg::ST_CTG;
      wpt_pkg::ST_CTG: state_nxt = wpt_pkg::ST_CORR;
      wpt_pkg::ST_CORR: begin
        state_nxt = status.need_corr ? wpt_pkg::ST_CORR_WAIT : wpt_pkg::ST_SUM;
      end
      wpt_pkg::ST_CORR_WAIT: begin
        if (!status.atan_busy) state_nxt = wpt_pkg::ST_SUM;
      end
      wpt_pkg::ST_SUM: state_nxt = wpt_pkg::ST_ANG;
      wpt_pkg::ST_ANG: state_nxt = wpt_pkg::ST_FIN;
      wpt_pkg::ST_FIN: begin
        if (out_free) state_nxt = wpt_pkg::ST_IDLE;
      end
      default: state_nxt = wpt_pkg::ST_IDLE;
    endcase
    // Step counter restarts on every state change
    cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != wpt_pkg::ST_IDLE);
    case (state_r)
      wpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (wpt_pkg::op_t'(in_operation))
            wpt_pkg::OP_CLEAR:  cmd.wp_clear  = 1'b1;
            wpt_pkg::OP_APPEND: cmd.wp_append = 1'b1;
            wpt_pkg::OP_POSE:   cmd.pose_cap  = 1'b1;
            wpt_pkg::OP_TICK:   cmd.scan_init = 1'b1;
            default: begin
            end
          endcase
        end
      end
      wpt_pkg::ST_POSE_MUL:  cmd.pose_mul  = 1'b1;
      wpt_pkg::ST_POSE_ATAN: cmd.pose_atan = 1'b1;
      wpt_pkg::ST_POSE_WAIT: cmd.yaw_load  = !status.atan_busy;
      wpt_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        cmd.rd_addr    = cnt_r[wpt_pkg::AW-1:0];
      end
      wpt_pkg::ST_DRAIN:     cmd.tgt_rd     = 1'b0;
      wpt_pkg::ST_TGT:       cmd.tgt_load   = 1'b1;
      wpt_pkg::ST_TGT_RD:    cmd.tgt_rd     = 1'b1;
      wpt_pkg::ST_DELTA:     cmd.delta_load = 1'b1;
      wpt_pkg::ST_SQ:        cmd.sq_load    = 1'b1;
      wpt_pkg::ST_ROOT_INIT: cmd.root_init  = 1'b1;
      wpt_pkg::ST_ROOT:      cmd.root_step  = 1'b1;
      wpt_pkg::ST_HEAD_WAIT: cmd.d_load     = 1'b1;
      wpt_pkg::ST_ERR:       cmd.err_load   = 1'b1;
      wpt_pkg::ST_CTG:       cmd.ctg_load   = 1'b1;
      wpt_pkg::ST_CORR:      cmd.corr_start = status.need_corr;
      wpt_pkg::ST_SUM:       cmd.sum_load   = 1'b1;
      wpt_pkg::ST_ANG:       cmd.ang_load   = 1'b1;
      wpt_pkg::ST_FIN:       cmd.out_load   = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
